// ===== design/pump_job_queue_sequencer_macros.svh =====
// Assertion macros shared by the checker.
`ifndef PUMP_JOB_QUEUE_SEQUENCER_MACROS_SVH
`define PUMP_JOB_QUEUE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PJQS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PJQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pjqs_pkg.sv =====
package pjqs_pkg;

  localparam int PUMP_W = 4;
  localparam int SEC_W  = 16;
  localparam int TPS_W  = 20;
  localparam int LVL_OUT_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [TPS_W-1:0] TPS_RESET    = 20'd1000;
  localparam logic [SEC_W-1:0] MANUAL_RESET = 16'd60;

  // action codes
  localparam logic [1:0] ACT_TICK       = 2'd0;
  localparam logic [1:0] ACT_PUSH       = 2'd1;
  localparam logic [1:0] ACT_MANUAL_ON  = 2'd2;
  localparam logic [1:0] ACT_MANUAL_OFF = 2'd3;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_RUN_SECONDS = 1'b1;

  typedef struct packed {
    logic [1:0]        action;
    logic [PUMP_W-1:0] pump_index;
    logic [SEC_W-1:0]  run_seconds;
  } in_word_t;

  typedef struct packed {
    logic                 accepted;
    logic                 pump_on;
    logic [PUMP_W-1:0]    active_pump;
    logic                 job_ended;
    logic [LVL_OUT_W-1:0] queue_level;
  } out_word_t;

  typedef struct packed {
    logic [PUMP_W-1:0] pump;
    logic [SEC_W-1:0]  seconds;
  } queue_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;   // process the accepted word
    logic start;  // start the head job from the read register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_needed;  // current word is a tick that pops the head job
  } ctl_sts_t;

endpackage

// ===== design/pjqs_ctrl.sv =====
module pjqs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  pjqs_pkg::ctl_sts_t sts,
  output pjqs_pkg::ctl_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_t;

  state_t state;
  logic   accept;

  assign in_stall  = !(state == ST_IDLE && (!out_valid || !out_stall));
  assign accept    = in_valid && !in_stall;
  assign cmd.exec  = accept;
  assign cmd.start = (state == ST_FETCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && sts.start_needed) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if ((accept && !sts.start_needed) || cmd.start) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/pjqs_datapath.sv =====
module pjqs_datapath #(
  parameter int QUEUE_SLOTS = 8,
  parameter int PUMP_COUNT  = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pjqs_pkg::in_word_t                 in_word,
  input  logic                               cfg_valid,
  input  logic [pjqs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pjqs_pkg::TPS_W-1:0]         cfg_data,
  input  pjqs_pkg::ctl_cmd_t                 cmd,
  output pjqs_pkg::ctl_sts_t                 sts,
  output pjqs_pkg::out_word_t                out_word
);

  localparam int PTR_W = $clog2(QUEUE_SLOTS);
  localparam int LVL_W = (PTR_W + 1 > pjqs_pkg::LVL_OUT_W) ? PTR_W + 1 : pjqs_pkg::LVL_OUT_W;
  localparam int PW  = pjqs_pkg::PUMP_W;
  localparam int SW  = pjqs_pkg::SEC_W;
  localparam int TW  = pjqs_pkg::TPS_W;

  // job ring, no reset: an entry is read only after it was written
  pjqs_pkg::queue_entry_t mem [QUEUE_SLOTS];
  pjqs_pkg::queue_entry_t rd_entry;

  logic [TW-1:0]    tps;
  logic [SW-1:0]    manual_secs;
  logic [PTR_W-1:0] head, tail;
  logic             running;
  logic [PW-1:0]    cur_pump;
  logic [SW-1:0]    cur_dur;
  logic [TW-1:0]    tick_count;
  logic [SW-1:0]    sec_count;
  logic             stop_req;

  logic [PTR_W-1:0] head_next, tail_next, head_inc, tail_inc;
  logic             running_next, stop_next;
  logic [PW-1:0]    cur_pump_next;
  logic [SW-1:0]    cur_dur_next, sec_next, sec_inc;
  logic [TW-1:0]    tick_next, tps_eff;
  logic [TW:0]      tick_inc;
  logic             pump_ok, full, empty, second_done;
  logic             wr_en, accepted, ended, commit;
  logic [SW-1:0]    wr_secs;
  logic [LVL_W-1:0] level;
  pjqs_pkg::out_word_t out_next;

  assign pump_ok  = {1'b0, in_word.pump_index} < (PW + 1)'(PUMP_COUNT);
  assign tail_inc = (tail == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : tail + 1'b1;
  assign head_inc = (head == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : head + 1'b1;
  assign full     = (tail_inc == head);
  assign empty    = (head == tail);
  assign tps_eff  = (tps == '0) ? TW'(1) : tps;
  assign tick_inc = {1'b0, tick_count} + (TW + 1)'(1);
  assign sec_inc  = sec_count + SW'(1);
  assign second_done = (tick_inc >= {1'b0, tps_eff});
  assign commit   = cmd.exec || cmd.start;

  assign sts.start_needed = (in_word.action == pjqs_pkg::ACT_TICK) && !running && !empty;

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    running_next  = running;
    stop_next     = stop_req;
    cur_pump_next = cur_pump;
    cur_dur_next  = cur_dur;
    tick_next     = tick_count;
    sec_next      = sec_count;
    wr_en         = 1'b0;
    wr_secs       = in_word.run_seconds;
    accepted      = 1'b0;
    ended         = 1'b0;
    if (cmd.start) begin
      accepted      = 1'b1;
      running_next  = 1'b1;
      cur_pump_next = rd_entry.pump;
      cur_dur_next  = rd_entry.seconds;
      head_next     = head_inc;
      stop_next     = 1'b0;
      tick_next     = '0;
      sec_next      = '0;
    end else begin
      case (in_word.action)
        pjqs_pkg::ACT_TICK: begin
          accepted = 1'b1;
          if (running) begin
            if (stop_req) begin
              // stop wins over a normal end; flush the queue
              running_next = 1'b0;
              ended        = 1'b1;
              head_next    = tail;
              stop_next    = 1'b0;
            end else if (second_done) begin
              tick_next = '0;
              sec_next  = sec_inc;
              if (sec_inc >= cur_dur) begin
                running_next = 1'b0;
                ended        = 1'b1;
              end
            end else begin
              tick_next = tick_inc[TW-1:0];
            end
          end
        end
        pjqs_pkg::ACT_PUSH: begin
          if (pump_ok && in_word.run_seconds != '0 &&
              in_word.run_seconds <= manual_secs && !full) begin
            accepted  = 1'b1;
            wr_en     = 1'b1;
            tail_next = tail_inc;
          end
        end
        pjqs_pkg::ACT_MANUAL_ON: begin
          if (pump_ok && !running) begin
            accepted = 1'b1;
            // acknowledged even when nothing could be queued
            if (!full && manual_secs != '0) begin
              wr_en     = 1'b1;
              wr_secs   = manual_secs;
              tail_next = tail_inc;
            end
          end
        end
        pjqs_pkg::ACT_MANUAL_OFF: begin
          if (pump_ok) begin
            accepted  = 1'b1;
            stop_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    // waiting jobs, modulo the ring size
    level = LVL_W'(tail_next) - LVL_W'(head_next);
    if (tail_next < head_next) begin
      level = level + LVL_W'(QUEUE_SLOTS);
    end
    out_next.accepted    = accepted;
    out_next.pump_on     = running_next;
    out_next.active_pump = running_next ? cur_pump_next : '0;
    out_next.job_ended   = ended;
    out_next.queue_level = level[pjqs_pkg::LVL_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && !cmd.start && wr_en) begin
      mem[tail] <= '{pump: in_word.pump_index, seconds: wr_secs};
    end
    rd_entry <= mem[head];
    if (commit) begin
      out_word <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tps         <= pjqs_pkg::TPS_RESET;
      manual_secs <= pjqs_pkg::MANUAL_RESET;
      head        <= '0;
      tail        <= '0;
      running     <= 1'b0;
      cur_pump    <= '0;
      cur_dur     <= '0;
      tick_count  <= '0;
      sec_count   <= '0;
      stop_req    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == pjqs_pkg::REG_TICKS_PER_SECOND) begin
        tps <= cfg_data;
      end
      if (cfg_valid && cfg_index == pjqs_pkg::REG_MANUAL_RUN_SECONDS) begin
        manual_secs <= cfg_data[SW-1:0];
      end
      if (commit) begin
        head       <= head_next;
        tail       <= tail_next;
        running    <= running_next;
        cur_pump   <= cur_pump_next;
        cur_dur    <= cur_dur_next;
        tick_count <= tick_next;
        sec_count  <= sec_next;
        stop_req   <= stop_next;
      end
    end
  end

endmodule

// ===== design/pump_job_queue_sequencer.sv =====
// Results: each result word is registered; a tick that starts the head job
//   first waits in the fetch state for the registered read of the job ring.
// Throughput: one word per cycle while no result is held; the input stalls during a fetch.
// Reset (rst, synchronous, active high): queue empty, no job running, no stop
//   pending, ticks_per_second = 1000, manual_run_seconds = 60. Ring contents
//   are not cleared; no clearing pass is needed.
module pump_job_queue_sequencer #(
  parameter int QUEUE_SLOTS = 8,
  parameter int PUMP_COUNT  = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  // input words
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pjqs_pkg::in_word_t             in_word,
  // result words
  output logic                           out_valid,
  input  logic                           out_stall,
  output pjqs_pkg::out_word_t            out_word,
  // register writes: 0 ticks_per_second, 1 manual_run_seconds
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pjqs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pjqs_pkg::TPS_W-1:0]     cfg_data
);

  pjqs_pkg::ctl_cmd_t cmd;
  pjqs_pkg::ctl_sts_t sts;

  // Registers are plain flops, so writes are always accepted.
  assign cfg_ready = 1'b1;

  // Controller: handshakes, result-valid flag, and the fetch state that
  // waits for the ring read before a job starts.
  pjqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: job ring, pointers, tick and second counters, config
  // registers and the result register.
  pjqs_datapath #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .PUMP_COUNT  (PUMP_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (out_word)
  );

endmodule

// ===== design/pjqs_checker.sv =====
`include "pump_job_queue_sequencer_macros.svh"

module pjqs_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pjqs_pkg::out_word_t out_word
);

  logic out_held;
  logic in_taken;
  logic ended;
  logic idle_ok;

  assign out_held = out_valid && out_stall;
  assign in_taken = in_valid && !in_stall;
  assign ended    = out_valid && out_word.job_ended;
  assign idle_ok  = !out_word.pump_on && out_word.accepted;

  `PJQS_ASSERT_NEXT(a_out_hold, clk, rst, out_held, out_valid && $stable(out_word), "held word moved")
  `PJQS_ASSERT_NOW(a_ended_idle, clk, rst, ended, idle_ok, "ended job still drives pump")
  `PJQS_ASSERT_NOW(a_full_stalls, clk, rst, out_held, in_stall, "input taken while result held")
  `PJQS_ASSERT_NEXT(a_result_follows, clk, rst, in_taken, out_valid || in_stall, "no result after word")

endmodule

bind pump_job_queue_sequencer pjqs_checker u_checker (.*);
